/* rtl/pn3_pkg.sv */
// Shared types and constants for the 3D gradient noise block.
// No dependencies; every other file of the block imports this package.
package pn3_pkg;

    // Fractional bits of the coordinates unless the top level overrides them.
    localparam int FRAC_BITS_DEF = 16;

    // Permutation table geometry.
    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = $clog2(TABLE_SIZE);

    // Depth of the queue between the front and back parts (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Item command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Result saturation bound in Q2.16.
    localparam int SAT_MAX   = 131072;
    localparam int OUT_WIDTH = 19;

    typedef struct packed {
        logic                cmd;
        logic [7:0]          table_index;
        logic [7:0]          table_value;
        logic [31:0]         coord_x;
        logic [31:0]         coord_y;
        logic [31:0]         coord_z;
    } pn3_item_t;

endpackage

/* rtl/pn3_queue.sv */
// Front part: accepts items and holds them in a short queue for the back part.
// Depends on pn3_pkg for the item type and the queue depth.
module pn3_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pn3_pkg::pn3_item_t in_item,
    output logic              head_valid,
    output pn3_pkg::pn3_item_t head_item,
    input  logic              pop
);
    import pn3_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    pn3_item_t        slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;
    logic             push;

    assign in_ready   = (count_reg != (QAW + 1)'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

/* rtl/pn3_perm_ram.sv */
// One copy of the 256-entry permutation table: one write port, two registered reads.
// Depends on pn3_pkg for the table geometry.
module pn3_perm_ram (
    input  logic                        clk,
    input  logic                        en,
    input  logic                        wr_en,
    input  logic [pn3_pkg::TABLE_AW-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic [pn3_pkg::TABLE_AW-1:0] rd_addr_a,
    input  logic [pn3_pkg::TABLE_AW-1:0] rd_addr_b,
    output logic [7:0]                  rd_data_a,
    output logic [7:0]                  rd_data_b
);
    import pn3_pkg::*;

    logic [7:0] mem [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* rtl/pn3_fade.sv */
// Four-stage pipelined quintic fade 6t^5 - 15t^4 + 10t^3 in fixed point.
// Depends on pn3_pkg only for the default fraction width.
module pn3_fade #(
    parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [FRAC_BITS-1:0] t,
    output logic [FRAC_BITS+1:0] fade
);
    import pn3_pkg::*;

    localparam int F = FRAC_BITS;
    localparam logic signed [F+4:0]   K15 = (F + 5)'(15) <<< F;
    localparam logic signed [2*F+5:0] K10 = (2 * F + 6)'(10) <<< F;

    logic signed [F+4:0]   d6;
    logic signed [2*F+5:0] p_next;

    logic [F-1:0]          t_a_reg;
    logic [2*F-1:0]        tt_a_reg;
    logic signed [2*F+5:0] tp_a_reg;
    logic [2*F-1:0]        c2_b_reg;
    logic [F+3:0]          p_b_reg;
    logic [2*F+3:0]        cp_c_reg;
    logic [F+1:0]          fade_reg;

    assign d6     = $signed((F + 5)'({t, 2'b00})) + $signed((F + 5)'({t, 1'b0})) - K15;
    assign p_next = (tp_a_reg >>> F) + K10;
    assign fade   = fade_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_a_reg  <= t;
            tt_a_reg <= t * t;
            tp_a_reg <= $signed({1'b0, t}) * d6;
            c2_b_reg <= tt_a_reg[2*F-1:F] * t_a_reg;
            p_b_reg  <= p_next[F+3:0];
            cp_c_reg <= c2_b_reg[2*F-1:F] * p_b_reg;
            fade_reg <= cp_c_reg[2*F+1:F];
        end
    end

endmodule

/* rtl/pn3_back.sv */
// Back part: table hashing, gradients, trilinear blend and the output register.
// Depends on pn3_pkg, pn3_perm_ram and pn3_fade.
module pn3_back #(
    parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  pn3_pkg::pn3_item_t            head_item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [pn3_pkg::OUT_WIDTH-1:0] noise_value
);
    import pn3_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int VW  = F + 4;
    localparam int DW  = F + 5;
    localparam int FW  = F + 2;
    localparam int PW  = 2 * F + 8;
    localparam int XW  = VW + 17;
    localparam int SHR = (F >= 16) ? F - 16 : 0;
    localparam int SHL = (F < 16) ? 16 - F : 0;
    localparam logic signed [VW-1:0] ONE    = (VW)'(1) <<< F;
    localparam logic signed [XW-1:0] SAT_HI = (XW)'(SAT_MAX);
    localparam logic signed [XW-1:0] SAT_LO = -((XW)'(SAT_MAX));

    function automatic logic signed [VW-1:0] grad(
        input logic [3:0]             h,
        input logic signed [VW-1:0]   dx,
        input logic signed [VW-1:0]   dy,
        input logic signed [VW-1:0]   dz
    );
        logic signed [VW-1:0] gu;
        logic signed [VW-1:0] gv;
        gu = (h < 4'd8) ? dx : dy;
        gv = (h < 4'd4) ? dy : (((h == 4'd12) || (h == 4'd14)) ? dx : dz);
        gu = h[0] ? -gu : gu;
        gv = h[1] ? -gv : gv;
        return gu + gv;
    endfunction

    function automatic logic signed [VW-1:0] lerp_end(
        input logic signed [VW-1:0] lo,
        input logic signed [PW-1:0] m
    );
        logic signed [PW-1:0] sh;
        sh = m >>> F;
        return lo + (VW)'(sh);
    endfunction

    logic adv;

    // stage 1
    logic                 s1_vld_reg;
    logic                 s1_cmd_reg;
    logic [7:0]           s1_idx_reg;
    logic [7:0]           s1_val_reg;
    logic [7:0]           s1_iy_reg;
    logic [7:0]           s1_iz_reg;
    logic [F-1:0]         s1_fx_reg;
    logic [F-1:0]         s1_fy_reg;
    logic [F-1:0]         s1_fz_reg;
    logic [7:0]           p_ix;
    logic [7:0]           p_ix1;
    // stage 2
    logic                 s2_vld_reg;
    logic                 s2_cmd_reg;
    logic [7:0]           s2_idx_reg;
    logic [7:0]           s2_val_reg;
    logic [7:0]           s2_iz_reg;
    logic [F-1:0]         s2_fx_reg;
    logic [F-1:0]         s2_fy_reg;
    logic [F-1:0]         s2_fz_reg;
    logic [7:0]           p_a;
    logic [7:0]           p_a1;
    logic [7:0]           p_b;
    logic [7:0]           p_b1;
    logic [7:0]           base3 [4];
    // stage 3
    logic [F-1:0]         s3_fx_reg;
    logic [F-1:0]         s3_fy_reg;
    logic [F-1:0]         s3_fz_reg;
    logic [7:0]           hash3 [8];
    // evaluation valid bits, stage 3 onwards
    logic [9:3]           ev_reg;
    // stage 4
    logic signed [VW-1:0] g4_reg [8];
    logic [FW-1:0]        fu;
    logic [FW-1:0]        fv;
    logic [FW-1:0]        fw;
    // stages 5 to 9
    logic signed [PW-1:0] m5_reg [4];
    logic signed [VW-1:0] lo5_reg [4];
    logic [FW-1:0]        fv5_reg;
    logic [FW-1:0]        fw5_reg;
    logic signed [VW-1:0] l1_reg [4];
    logic [FW-1:0]        fv6_reg;
    logic [FW-1:0]        fw6_reg;
    logic signed [PW-1:0] m7_reg [2];
    logic signed [VW-1:0] lo7_reg [2];
    logic [FW-1:0]        fw7_reg;
    logic signed [VW-1:0] l2_reg [2];
    logic [FW-1:0]        fw8_reg;
    logic signed [PW-1:0] m9_reg;
    logic signed [VW-1:0] lo9_reg;
    // output
    logic                        out_valid_reg;
    logic signed [OUT_WIDTH-1:0] noise_reg;
    logic signed [OUT_WIDTH-1:0] noise_next;
    logic signed [VW-1:0]        r_fin;
    logic signed [XW-1:0]        r_scaled;

    assign adv         = !out_valid_reg || out_ready;
    assign pop         = adv && head_valid;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

    // Table copy for the first lookup, written as a write item leaves the queue.
    pn3_perm_ram u_ram0 (
        .clk       (clk),
        .en        (adv),
        .wr_en     (pop && (head_item.cmd == CMD_WRITE)),
        .wr_addr   (head_item.table_index),
        .wr_data   (head_item.table_value),
        .rd_addr_a (head_item.coord_x[F+7:F]),
        .rd_addr_b (head_item.coord_x[F+7:F] + 8'd1),
        .rd_data_a (p_ix),
        .rd_data_b (p_ix1)
    );

    pn3_perm_ram u_ram1 (
        .clk       (clk),
        .en        (adv),
        .wr_en     (adv && s1_vld_reg && (s1_cmd_reg == CMD_WRITE)),
        .wr_addr   (s1_idx_reg),
        .wr_data   (s1_val_reg),
        .rd_addr_a (p_ix + s1_iy_reg),
        .rd_addr_b (p_ix + s1_iy_reg + 8'd1),
        .rd_data_a (p_a),
        .rd_data_b (p_a1)
    );

    pn3_perm_ram u_ram2 (
        .clk       (clk),
        .en        (adv),
        .wr_en     (adv && s1_vld_reg && (s1_cmd_reg == CMD_WRITE)),
        .wr_addr   (s1_idx_reg),
        .wr_data   (s1_val_reg),
        .rd_addr_a (p_ix1 + s1_iy_reg),
        .rd_addr_b (p_ix1 + s1_iy_reg + 8'd1),
        .rd_data_a (p_b),
        .rd_data_b (p_b1)
    );

    assign base3[0] = p_a  + s2_iz_reg;
    assign base3[1] = p_b  + s2_iz_reg;
    assign base3[2] = p_a1 + s2_iz_reg;
    assign base3[3] = p_b1 + s2_iz_reg;

    // Corner k has offsets x = k[0], y = k[1], z = k[2].
    for (genvar g = 0; g < 4; g++)
    begin : g_corner_ram
        pn3_perm_ram u_ram (
            .clk       (clk),
            .en        (adv),
            .wr_en     (adv && s2_vld_reg && (s2_cmd_reg == CMD_WRITE)),
            .wr_addr   (s2_idx_reg),
            .wr_data   (s2_val_reg),
            .rd_addr_a (base3[g]),
            .rd_addr_b (base3[g] + 8'd1),
            .rd_data_a (hash3[g]),
            .rd_data_b (hash3[g+4])
        );
    end

    pn3_fade #(.FRAC_BITS(F)) u_fade_x (
        .clk(clk), .en(adv), .t(head_item.coord_x[F-1:0]), .fade(fu)
    );
    pn3_fade #(.FRAC_BITS(F)) u_fade_y (
        .clk(clk), .en(adv), .t(head_item.coord_y[F-1:0]), .fade(fv)
    );
    pn3_fade #(.FRAC_BITS(F)) u_fade_z (
        .clk(clk), .en(adv), .t(head_item.coord_z[F-1:0]), .fade(fw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            ev_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= head_valid;
            s2_vld_reg    <= s1_vld_reg;
            ev_reg        <= {ev_reg[8:3], s2_vld_reg && (s2_cmd_reg == CMD_EVAL)};
            out_valid_reg <= ev_reg[9];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= head_item.cmd;
            s1_idx_reg <= head_item.table_index;
            s1_val_reg <= head_item.table_value;
            s1_iy_reg  <= head_item.coord_y[F+7:F];
            s1_iz_reg  <= head_item.coord_z[F+7:F];
            s1_fx_reg  <= head_item.coord_x[F-1:0];
            s1_fy_reg  <= head_item.coord_y[F-1:0];
            s1_fz_reg  <= head_item.coord_z[F-1:0];

            s2_cmd_reg <= s1_cmd_reg;
            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
            s2_iz_reg  <= s1_iz_reg;
            s2_fx_reg  <= s1_fx_reg;
            s2_fy_reg  <= s1_fy_reg;
            s2_fz_reg  <= s1_fz_reg;

            s3_fx_reg  <= s2_fx_reg;
            s3_fy_reg  <= s2_fy_reg;
            s3_fz_reg  <= s2_fz_reg;
        end
    end

    // Gradients at the eight corners.
    for (genvar k = 0; k < 8; k++)
    begin : g_grad
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        logic signed [VW-1:0] dz;
        assign dx = $signed((VW)'(s3_fx_reg)) - (k[0] ? ONE : '0);
        assign dy = $signed((VW)'(s3_fy_reg)) - (k[1] ? ONE : '0);
        assign dz = $signed((VW)'(s3_fz_reg)) - (k[2] ? ONE : '0);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                g4_reg[k] <= grad(hash3[k][3:0], dx, dy, dz);
            end
        end
    end

    // First blend along x, four pairs.
    for (genvar j = 0; j < 4; j++)
    begin : g_lerp_x
        logic signed [DW-1:0] d;
        assign d = (DW)'(g4_reg[2*j+1]) - (DW)'(g4_reg[2*j]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m5_reg[j]  <= $signed({1'b0, fu}) * d;
                lo5_reg[j] <= g4_reg[2*j];
                l1_reg[j]  <= lerp_end(lo5_reg[j], m5_reg[j]);
            end
        end
    end

    // Blend along y, two pairs.
    for (genvar j = 0; j < 2; j++)
    begin : g_lerp_y
        logic signed [DW-1:0] d;
        assign d = (DW)'(l1_reg[2*j+1]) - (DW)'(l1_reg[2*j]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m7_reg[j]  <= $signed({1'b0, fv6_reg}) * d;
                lo7_reg[j] <= l1_reg[2*j];
                l2_reg[j]  <= lerp_end(lo7_reg[j], m7_reg[j]);
            end
        end
    end

    logic signed [DW-1:0] dz9;
    assign dz9 = (DW)'(l2_reg[1]) - (DW)'(l2_reg[0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fv5_reg <= fv;
            fw5_reg <= fw;
            fv6_reg <= fv5_reg;
            fw6_reg <= fw5_reg;
            fw7_reg <= fw6_reg;
            fw8_reg <= fw7_reg;
            m9_reg  <= $signed({1'b0, fw8_reg}) * dz9;
            lo9_reg <= l2_reg[0];
        end
    end

    // Final blend along z, rescale to 16 fraction bits and saturate.
    assign r_fin    = lerp_end(lo9_reg, m9_reg);
    assign r_scaled = ((XW)'(r_fin) >>> SHR) <<< SHL;

    always_comb
    begin
        priority if (r_scaled > SAT_HI)
        begin
            noise_next = (OUT_WIDTH)'(SAT_HI);
        end
        else if (r_scaled < SAT_LO)
        begin
            noise_next = (OUT_WIDTH)'(SAT_LO);
        end
        else
        begin
            noise_next = (OUT_WIDTH)'(r_scaled);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ev_reg[9])
        begin
            noise_reg <= noise_next;
        end
    end

`ifndef SYNTH
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(ev_reg) && $stable(s1_vld_reg) && $stable(s2_vld_reg)))
        else $error("pipeline moved while stalled");
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ev_reg[9]) |=> out_valid_reg)
        else $error("evaluation lost before output");
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((noise_reg <= (OUT_WIDTH)'(SAT_HI))
                           && (noise_reg >= (OUT_WIDTH)'(SAT_LO))))
        else $error("result outside saturation range");
`endif

endmodule

/* rtl/perlin_noise_3d.sv */
// Top level of the 3D improved gradient noise block.
// Depends on pn3_pkg, pn3_queue and pn3_back.
//
// Usage:
// The input channel (in_valid / in_ready) carries one item per handshake. An item
// with cmd = write stores table_value at table_index in the 256-entry permutation
// table and gives no result. An item with cmd = evaluate takes coord_x, coord_y and
// coord_z in signed Q16.16 and gives one result item on the output channel
// (out_valid / out_ready): noise_value in signed Q2.16, saturated to -2.0 .. +2.0
// of the Q2.16 range (plus or minus 131072).
// Throughput is one item per cycle while the output is not stalled. On its way
// to the output register an item passes the three dependent permutation lookups
// and the three blend levels, with the multiply stages of the fade alongside the
// lookups. Write items flow through the same pipeline, so each of the seven table
// copies sees the write in order with the evaluations. A four-item queue separates
// acceptance from the pipeline: when a result waits and the receiver holds
// out_ready low, the pipeline freezes and the queue keeps taking items until it
// is full. Reset empties the queue and the pipeline; the table contents are not
// cleared, and entries must be written before an evaluation hashes to them.
module perlin_noise_3d #(
    parameter int FRAC_BITS = pn3_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [pn3_pkg::OUT_WIDTH-1:0] noise_value
);
    import pn3_pkg::*;

    pn3_item_t in_item;
    pn3_item_t head_item;
    logic      head_valid;
    logic      pop;

    // Bundle the item fields for the queue.
    assign in_item.cmd         = cmd;
    assign in_item.table_index = table_index;
    assign in_item.table_value = table_value;
    assign in_item.coord_x     = coord_x;
    assign in_item.coord_y     = coord_y;
    assign in_item.coord_z     = coord_z;

    pn3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    pn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .noise_value (noise_value)
    );

endmodule

/* tb/sv/perlin_noise_3d_test.sv */
// Self-checking testbench for perlin_noise_3d: table writes and noise evaluations.
// Depends on pn3_pkg and the perlin_noise_3d RTL; predicts every result internally.
`timescale 1ns / 1ps

module perlin_noise_3d_test;
    import pn3_pkg::*;

    localparam int  FRAC  = 16;
    localparam longint ONE = 64'sd1 <<< FRAC;
    localparam int  LATENCY_SLACK = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic        out_valid;
    logic        out_ready;
    logic signed [OUT_WIDTH-1:0] noise_value;

    perlin_noise_3d dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .table_index (table_index),
        .table_value (table_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .noise_value (noise_value)
    );

    // Our own copy of the permutation table, updated in acceptance order.
    logic [7:0] perm_shadow [TABLE_SIZE];
    // Noise values still owed by the block, oldest first.
    logic signed [OUT_WIDTH-1:0] noise_owed [$];

    int mismatches;
    int unexpected;
    int evals_sent;
    int writes_sent;
    int noise_seen;
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Generous ceiling on the whole run; a correct run finishes far sooner.
    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // Quintic fade 6t^5 - 15t^4 + 10t^3 with the same flooring steps as the block.
    // The arithmetic shift on a signed longint floors toward minus infinity.
    function automatic longint fade_q(input longint t);
        longint p;
        longint c;
        p = ((t * (6 * t - 15 * ONE)) >>> FRAC) + 10 * ONE;
        c = (((t * t) >>> FRAC) * t) >>> FRAC;
        return (c * p) >>> FRAC;
    endfunction

    function automatic longint blend_q(input longint t, input longint a, input longint b);
        return a + ((t * (b - a)) >>> FRAC);
    endfunction

    // One of the sixteen gradient dot products, chosen by the low hash nibble.
    function automatic longint grad_q(input logic [7:0] hash, input longint dx,
                                      input longint dy, input longint dz);
        logic [3:0] h;
        longint     u;
        longint     v;
        h = hash[3:0];
        u = (h < 4'd8) ? dx : dy;
        v = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : dz);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] noise_predict(
        input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz);
        logic [7:0] ix, iy, iz;
        logic [7:0] a, aa, ab, b, ba, bb;
        longint x, y, z, u, v, w, r;
        ix = cx[FRAC+7:FRAC];
        iy = cy[FRAC+7:FRAC];
        iz = cz[FRAC+7:FRAC];
        x  = longint'(cx[FRAC-1:0]);
        y  = longint'(cy[FRAC-1:0]);
        z  = longint'(cz[FRAC-1:0]);
        u  = fade_q(x);
        v  = fade_q(y);
        w  = fade_q(z);
        // All index sums wrap at 8 bits, which is the mod 256 of the hash.
        a  = perm_shadow[ix] + iy;
        aa = perm_shadow[a] + iz;
        ab = perm_shadow[8'(a + 1)] + iz;
        b  = perm_shadow[8'(ix + 1)] + iy;
        ba = perm_shadow[b] + iz;
        bb = perm_shadow[8'(b + 1)] + iz;
        r = blend_q(w,
                blend_q(v,
                    blend_q(u, grad_q(perm_shadow[aa], x, y, z),
                               grad_q(perm_shadow[ba], x - ONE, y, z)),
                    blend_q(u, grad_q(perm_shadow[ab], x, y - ONE, z),
                               grad_q(perm_shadow[bb], x - ONE, y - ONE, z))),
                blend_q(v,
                    blend_q(u, grad_q(perm_shadow[8'(aa + 1)], x, y, z - ONE),
                               grad_q(perm_shadow[8'(ba + 1)], x - ONE, y, z - ONE)),
                    blend_q(u, grad_q(perm_shadow[8'(ab + 1)], x, y - ONE, z - ONE),
                               grad_q(perm_shadow[8'(bb + 1)], x - ONE, y - ONE,
                                      z - ONE))));
        // With sixteen fractional bits the result is already in Q2.16.
        if (r > SAT_MAX)
            r = SAT_MAX;
        if (r < -SAT_MAX)
            r = -SAT_MAX;
        return r[OUT_WIDTH-1:0];
    endfunction

    // Sends one item, honouring the burst pattern of the sender. Inputs change
    // on the falling edge; acceptance is judged on the rising edge.
    task automatic send_item(input logic c, input logic [7:0] idx, input logic [7:0] val,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid    = 1'b1;
        cmd         = c;
        table_index = idx;
        table_value = val;
        coord_x     = x;
        coord_y     = y;
        coord_z     = z;
        do
            @(posedge clk);
        while (!in_ready);
        if (c == CMD_WRITE)
        begin
            perm_shadow[idx] = val;
            writes_sent++;
        end
        else
        begin
            noise_owed = {noise_owed, noise_predict(x, y, z)};
            evals_sent++;
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_write(input logic [7:0] idx, input logic [7:0] val);
        send_item(CMD_WRITE, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic send_eval(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        send_item(CMD_EVAL, 8'($urandom), 8'($urandom), x, y, z);
    endtask

    // Every entry is written before any evaluation, since unwritten entries
    // hold nothing defined. The extreme byte values are placed deliberately.
    task automatic test_table_load();
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (i == 0)
                send_write(8'(i), 8'hFF);
            else if (i == 255)
                send_write(8'(i), 8'h00);
            else
                send_write(8'(i), 8'($urandom));
        end
    endtask

    // Directed points: lattice corners, the largest fraction, the extreme
    // coordinates and the wrap of the cell index past 255.
    task automatic test_directed_points();
        send_eval(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_eval(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_eval(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        send_eval(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_eval(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        send_eval(32'h00FF_4000, 32'h00FF_C000, 32'h00FF_0001);
        send_eval(32'hFFFF_8000, 32'h7FFF_0000, 32'h0000_0001);
        send_eval(32'h1234_5678, 32'hDEAD_BEEF, 32'hA5A5_5A5A);
    endtask

    // Rewrite a few entries with extreme bytes and evaluate straight after, so
    // the write must reach every table copy before the following evaluation.
    task automatic test_rewrite_order();
        send_write(8'h00, 8'h00);
        send_eval(32'h0000_4000, 32'h0000_4000, 32'h0000_4000);
        send_write(8'h01, 8'hFF);
        send_eval(32'h0000_C000, 32'h0001_2000, 32'h0000_0800);
        send_write(8'hFF, 8'hFF);
        send_eval(32'h00FF_7FFF, 32'h00FF_7FFF, 32'h00FF_7FFF);
    endtask

    task automatic test_random_mix(input int n);
        logic [31:0] p [3];
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_write(8'($urandom), 8'($urandom));
            else
            begin
                for (int j = 0; j < 3; j++)
                begin
                    // Mostly full range; some near the origin and the cell wrap.
                    case ($urandom_range(0, 3))
                        0:       p[j] = $urandom_range(0, 32'h0003_FFFF);
                        1:       p[j] = {8'($urandom), 8'hFF, 16'($urandom)};
                        default: p[j] = $urandom;
                    endcase
                end
                send_eval(p[0], p[1], p[2]);
            end
        end
    endtask

    // Receiver: long stretches always ready, alternating with random stalls.
    initial
    begin
        int run;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(5, 60);
            if ($urandom_range(0, 2) == 0)
            begin
                out_ready = 1'b1;
                repeat (run) @(negedge clk);
            end
            else
            begin
                repeat (run)
                begin
                    out_ready = ($urandom_range(0, 2) != 0);
                    @(negedge clk);
                end
            end
        end
    end

    // Result checker: each accepted result is matched against the oldest owed value.
    always @(posedge clk)
    begin
        logic signed [OUT_WIDTH-1:0] owed;
        if (rst_n && out_valid && out_ready)
        begin
            noise_seen++;
            if (noise_owed.size() == 0)
            begin
                unexpected++;
                $display("unexpected noise result %0d with nothing owed", noise_value);
            end
            else
            begin
                owed = noise_owed.pop_front();
                if (noise_value !== owed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d, got %0d", owed,
                                 noise_value);
                end
            end
        end
    end

    initial
    begin
        int waited;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = CMD_WRITE;
        table_index = '0;
        table_value = '0;
        coord_x     = '0;
        coord_y     = '0;
        coord_z     = '0;
        mismatches  = 0;
        unexpected  = 0;
        evals_sent  = 0;
        writes_sent = 0;
        noise_seen  = 0;
        burst_left  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_table_load();
        test_directed_points();
        test_rewrite_order();
        test_random_mix(1430);

        // Drain: wait for every owed result, then a little longer for strays.
        waited = 0;
        while (noise_owed.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_SLACK) @(posedge clk);

        $display("covered %0d table writes and %0d noise evaluations, %0d results checked",
                 writes_sent, evals_sent, noise_seen);
        $display("%0d mismatches, %0d unexpected, %0d still owed", mismatches, unexpected,
                 noise_owed.size());
        if (mismatches == 0 && unexpected == 0 && noise_owed.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
